>>> src/hslg_pkg.sv
// ============================================================================
// hslg_pkg
// Shared types and constants for the hourly sample log with gap fill.
// ============================================================================
package hslg_pkg;

    localparam int LOG_DEPTH_DEFAULT = 168;
    localparam int HOUR_W            = 32;
    localparam int LEVEL_W           = 7;
    localparam int MV_W              = 16;
    localparam int GAP_W             = 12;
    localparam int OUT_COUNT_W       = 8;
    localparam logic [11:0] MAX_GAP_RESET = 12'd168;
    localparam logic [6:0]  LEVEL_MAX     = 7'd100;

    // Divider operand widths: dividend is twice a millivolt difference,
    // divisor is twice a gap of up to 4095 hours.
    localparam int DVD_W = 17;
    localparam int DVS_W = 13;

    // Mark bit positions inside an entry.
    localparam int MARK_INTERP_BIT = 0;
    localparam int MARK_LIGHT_BIT  = 1;
    localparam int MARK_DEEP_BIT   = 2;

    localparam logic MODE_RECORD = 1'b0;
    localparam logic MODE_LOOKUP = 1'b1;

    typedef struct packed {
        logic [HOUR_W-1:0]  hour;
        logic [LEVEL_W-1:0] level;
        logic [MV_W-1:0]    mv;
        logic [2:0]         marks;
    } entry_t;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] quotient;
        logic [DVS_W-1:0] remainder;
    } div_rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_NEWEST,
        ST_CHECK,
        ST_DIVIDE,
        ST_FILL,
        ST_APPEND,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_DONE
    } state_t;

endpackage

>>> src/hslg_in_if.sv
// ============================================================================
// hslg_in_if
// Input channel: one record or lookup item per handshake.
// ============================================================================
interface hslg_in_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [31:0] hour;
    logic [6:0]  level;
    logic [15:0] millivolts;
    logic [1:0]  sleep_mark;
    logic        gap_fill_en;

    modport source (output valid, mode, hour, level, millivolts, sleep_mark,
                    gap_fill_en, input ready);
    modport sink   (input valid, mode, hour, level, millivolts, sleep_mark,
                    gap_fill_en, output ready);
endinterface

>>> src/hslg_out_if.sv
// ============================================================================
// hslg_out_if
// Result channel: one result item for every input item.
// ============================================================================
interface hslg_out_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [6:0]  found_level;
    logic [15:0] found_millivolts;
    logic        was_interpolated;
    logic        light_sleep;
    logic        deep_sleep;
    logic [7:0]  stored_entries;

    modport source (output valid, found, found_level, found_millivolts,
                    was_interpolated, light_sleep, deep_sleep, stored_entries,
                    input ready);
    modport sink   (input valid, found, found_level, found_millivolts,
                    was_interpolated, light_sleep, deep_sleep, stored_entries,
                    output ready);
endinterface

>>> src/hslg_cfg_if.sv
// ============================================================================
// hslg_cfg_if
// Configuration write channel for the gap limit register.
// ============================================================================
interface hslg_cfg_if;
    logic        valid;
    logic        ready;
    logic [11:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

>>> src/hslg_div.sv
// ============================================================================
// hslg_div
// Restoring unsigned divider, one quotient bit per cycle.
// ============================================================================
module hslg_div
    import hslg_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] dvd_reg, dvd_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DVS_W:0]   trial;

    always_comb
    begin
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, dvd_reg[DVD_W-1]};
        if (req.start)
        begin
            dvd_next  = req.dividend;
            dvs_next  = req.divisor;
            rem_next  = '0;
            cnt_next  = CNT_W'(DVD_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = DVS_W'(trial - {1'b0, dvs_reg});
                dvd_next = {dvd_reg[DVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DVS_W-1:0];
                dvd_next = {dvd_reg[DVD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = dvd_reg;
    assign rsp.remainder = rem_reg;

endmodule

>>> src/hourly_sample_log_with_gap_fill.sv
// ============================================================================
// hourly_sample_log_with_gap_fill
// Ring log of hourly battery samples with interpolated gap fill and lookup.
// ============================================================================
//
//  Channel     Dir  Handshake      Carries
//  sample_in   in   valid/ready    mode, hour, level, millivolts, marks, fill
//  result_out  out  valid/ready    found entry fields, stored entry count
//  cfg         in   valid/ready    max_gap_hours (always ready)
//
//  One item is in flight at a time. A record reads and checks the newest
//  entry; when a gap is filled it runs the two slope divisions in parallel
//  and writes each filled hour before the append. A lookup reads and
//  compares the entries from the oldest on, one at a time, through the
//  single entry memory. Reset clears the state, pointers, counters, output
//  valid and gap limit; entry contents are never read before being written,
//  so there is no clearing pass. A stalled result waits in the output
//  register while the next item is accepted; that item finishes only once the register is free.
//
module hourly_sample_log_with_gap_fill
    import hslg_pkg::*;
#(
    parameter int LOG_DEPTH = LOG_DEPTH_DEFAULT
)
(
    input  logic         clk,
    input  logic         rst_n,
    hslg_in_if.sink      sample_in,
    hslg_out_if.source   result_out,
    hslg_cfg_if.sink     cfg
);

    localparam int IW = $clog2(LOG_DEPTH);
    localparam int TW = $clog2(LOG_DEPTH + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(LOG_DEPTH - 1);
    localparam logic [TW-1:0] DEPTH_T  = TW'(LOG_DEPTH);

    // Entry memory: synchronous write, registered read.
    entry_t          mem [LOG_DEPTH];
    entry_t          rd_data;
    logic            rd_en;
    logic [IW-1:0]   rd_addr;
    logic            wr_en;
    logic [IW-1:0]   wr_addr;
    entry_t          wr_data;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

    // Control state.
    state_t        state_reg, state_next;
    logic [IW-1:0] wp_reg, wp_next;
    logic [TW-1:0] total_reg, total_next;
    logic [11:0]   max_gap_reg;
    logic          out_valid_reg, out_valid_next;

    // Item and working registers (no reset needed).
    logic        mode_reg, mode_next;
    logic [31:0] hour_reg, hour_next;
    logic [6:0]  level_reg, level_next;
    logic [15:0] mv_reg, mv_next;
    logic [1:0]  sleep_reg, sleep_next;
    logic        fill_reg, fill_next;
    logic [6:0]  base_level_reg, base_level_next;
    logic [15:0] base_mv_reg, base_mv_next;
    logic [1:0]  base_sleep_reg, base_sleep_next;
    logic [12:0] span2_reg, span2_next;
    logic [11:0] cnt_reg, cnt_next;
    logic [31:0] fill_hour_reg, fill_hour_next;
    logic        neg_l_reg, neg_l_next;
    logic        neg_v_reg, neg_v_next;
    logic signed [17:0] q_l_reg, q_l_next, q_v_reg, q_v_next;
    logic signed [17:0] dq_l_reg, dq_l_next, dq_v_reg, dq_v_next;
    logic [12:0] r_l_reg, r_l_next, r_v_reg, r_v_next;
    logic [12:0] dr_l_reg, dr_l_next, dr_v_reg, dr_v_next;
    logic [IW-1:0] ptr_reg, ptr_next;
    logic [TW-1:0] scan_reg, scan_next;
    entry_t      res_reg, res_next;
    logic        res_found_reg, res_found_next;

    // Output payload registers.
    logic        o_found_reg;
    logic [6:0]  o_level_reg;
    logic [15:0] o_mv_reg;
    logic [2:0]  o_marks_reg;
    logic [7:0]  o_count_reg;
    logic        o_load;

    div_req_t div_l_req, div_v_req;
    div_rsp_t div_l_rsp, div_v_rsp;

    hslg_div u_div_level (.clk(clk), .rst_n(rst_n), .req(div_l_req), .rsp(div_l_rsp));
    hslg_div u_div_mv    (.clk(clk), .rst_n(rst_n), .req(div_v_req), .rsp(div_v_rsp));

    // Pointers derived from the write position.
    logic [IW-1:0] newest_idx;
    logic [IW-1:0] oldest_idx;
    logic [IW-1:0] wp_inc;
    logic [TW-1:0] total_inc;
    logic [TW:0]   old_sum;

    assign newest_idx = (wp_reg == '0) ? LAST_IDX : wp_reg - 1'b1;
    assign wp_inc     = (wp_reg == LAST_IDX) ? '0 : wp_reg + 1'b1;
    assign total_inc  = (total_reg < DEPTH_T) ? total_reg + 1'b1 : total_reg;
    assign old_sum    = (wp_reg >= IW'(total_reg))
                        ? (TW+1)'(wp_reg) - (TW+1)'(total_reg)
                        : (TW+1)'(wp_reg) + (TW+1)'(LOG_DEPTH) - (TW+1)'(total_reg);
    assign oldest_idx = (total_reg == DEPTH_T) ? wp_reg : IW'(old_sum);

    // Gap decision on the newest entry, compared without wrap.
    logic [32:0] base_plus1;
    logic [31:0] span;
    logic        is_gap;
    logic        span_ok;

    assign base_plus1 = {1'b0, rd_data.hour} + 33'd1;
    assign is_gap     = fill_reg && ({1'b0, hour_reg} > base_plus1);
    assign span       = hour_reg - rd_data.hour;
    assign span_ok    = span <= {20'd0, max_gap_reg};

    // Slope differences, as magnitude and sign.
    logic signed [7:0]  diff_l;
    logic signed [16:0] diff_v;
    logic [6:0]  mag_l;
    logic [15:0] mag_v;

    assign diff_l = $signed({1'b0, level_reg}) - $signed({1'b0, rd_data.level});
    assign diff_v = $signed({1'b0, mv_reg}) - $signed({1'b0, rd_data.mv});
    assign mag_l  = diff_l[7] ? 7'(-diff_l) : diff_l[6:0];
    assign mag_v  = diff_v[16] ? 16'(-diff_v) : diff_v[15:0];

    // Running quotient and remainder step for one interpolated hour.
    logic [13:0] sum_l, sum_v;
    logic        carry_l, carry_v;
    logic signed [17:0] q_l_step, q_v_step;

    assign sum_l    = {1'b0, r_l_reg} + {1'b0, dr_l_reg};
    assign sum_v    = {1'b0, r_v_reg} + {1'b0, dr_v_reg};
    assign carry_l  = sum_l >= {1'b0, span2_reg};
    assign carry_v  = sum_v >= {1'b0, span2_reg};
    assign q_l_step = q_l_reg + dq_l_reg + $signed({17'd0, carry_l});
    assign q_v_step = q_v_reg + dq_v_reg + $signed({17'd0, carry_v});

    entry_t item_entry;
    assign item_entry = '{hour: hour_reg, level: level_reg, mv: mv_reg,
                          marks: {sleep_reg, 1'b0}};

    always_comb
    begin
        logic [6:0] lv_sat;

        state_next      = state_reg;
        wp_next         = wp_reg;
        total_next      = total_reg;
        out_valid_next  = out_valid_reg;
        mode_next       = mode_reg;
        hour_next       = hour_reg;
        level_next      = level_reg;
        mv_next         = mv_reg;
        sleep_next      = sleep_reg;
        fill_next       = fill_reg;
        base_level_next = base_level_reg;
        base_mv_next    = base_mv_reg;
        base_sleep_next = base_sleep_reg;
        span2_next      = span2_reg;
        cnt_next        = cnt_reg;
        fill_hour_next  = fill_hour_reg;
        neg_l_next      = neg_l_reg;
        neg_v_next      = neg_v_reg;
        q_l_next        = q_l_reg;
        q_v_next        = q_v_reg;
        dq_l_next       = dq_l_reg;
        dq_v_next       = dq_v_reg;
        r_l_next        = r_l_reg;
        r_v_next        = r_v_reg;
        dr_l_next       = dr_l_reg;
        dr_v_next       = dr_v_reg;
        ptr_next        = ptr_reg;
        scan_next       = scan_reg;
        res_next        = res_reg;
        res_found_next  = res_found_reg;
        rd_en           = 1'b0;
        rd_addr         = newest_idx;
        wr_en           = 1'b0;
        wr_addr         = wp_reg;
        wr_data         = item_entry;
        div_l_req       = '{start: 1'b0, dividend: {3'd0, mag_l, 7'd0} >> 6,
                            divisor: {span[11:0], 1'b0}};
        div_v_req       = '{start: 1'b0, dividend: {mag_v, 1'b0},
                            divisor: {span[11:0], 1'b0}};
        o_load          = 1'b0;
        lv_sat          = (sample_in.level > LEVEL_MAX) ? LEVEL_MAX : sample_in.level;

        if (result_out.valid && result_out.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (sample_in.valid)
                begin
                    mode_next      = sample_in.mode;
                    hour_next      = sample_in.hour;
                    level_next     = lv_sat;
                    mv_next        = sample_in.millivolts;
                    sleep_next     = sample_in.sleep_mark;
                    fill_next      = sample_in.gap_fill_en;
                    res_found_next = 1'b0;
                    res_next       = '0;
                    if (sample_in.mode == MODE_LOOKUP)
                    begin
                        ptr_next   = oldest_idx;
                        scan_next  = total_reg;
                        state_next = (total_reg == '0) ? ST_DONE : ST_SCAN_RD;
                    end
                    else
                    begin
                        state_next = (total_reg == '0) ? ST_APPEND : ST_RD_NEWEST;
                    end
                end
            end

            ST_RD_NEWEST:
            begin
                rd_en      = 1'b1;
                rd_addr    = newest_idx;
                state_next = ST_CHECK;
            end

            ST_CHECK:
            begin
                if (is_gap && span_ok)
                begin
                    // Start both slope divisions and keep the base point.
                    div_l_req.start = 1'b1;
                    div_v_req.start = 1'b1;
                    base_level_next = rd_data.level;
                    base_mv_next    = rd_data.mv;
                    base_sleep_next = rd_data.marks[MARK_DEEP_BIT:MARK_LIGHT_BIT];
                    span2_next      = {span[11:0], 1'b0};
                    cnt_next        = span[11:0] - 12'd1;
                    fill_hour_next  = rd_data.hour + 32'd1;
                    neg_l_next      = diff_l[7];
                    neg_v_next      = diff_v[16];
                    state_next      = ST_DIVIDE;
                end
                else if (!is_gap && rd_data.hour == hour_reg)
                begin
                    // Same hour as the newest entry: update it in place.
                    wr_en      = 1'b1;
                    wr_addr    = newest_idx;
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_APPEND;
                end
            end

            ST_DIVIDE:
            begin
                if (div_l_rsp.done)
                begin
                    // Floor division of a signed slope by twice the span.
                    q_l_next = $signed({11'd0, base_level_reg});
                    q_v_next = $signed({2'd0, base_mv_reg});
                    r_l_next = {1'b0, span2_reg[12:1]};
                    r_v_next = {1'b0, span2_reg[12:1]};
                    if (!neg_l_reg)
                    begin
                        dq_l_next = $signed({1'b0, div_l_rsp.quotient});
                        dr_l_next = div_l_rsp.remainder;
                    end
                    else if (div_l_rsp.remainder == '0)
                    begin
                        dq_l_next = -$signed({1'b0, div_l_rsp.quotient});
                        dr_l_next = '0;
                    end
                    else
                    begin
                        dq_l_next = -$signed({1'b0, div_l_rsp.quotient}) - 18'sd1;
                        dr_l_next = span2_reg - div_l_rsp.remainder;
                    end
                    if (!neg_v_reg)
                    begin
                        dq_v_next = $signed({1'b0, div_v_rsp.quotient});
                        dr_v_next = div_v_rsp.remainder;
                    end
                    else if (div_v_rsp.remainder == '0)
                    begin
                        dq_v_next = -$signed({1'b0, div_v_rsp.quotient});
                        dr_v_next = '0;
                    end
                    else
                    begin
                        dq_v_next = -$signed({1'b0, div_v_rsp.quotient}) - 18'sd1;
                        dr_v_next = span2_reg - div_v_rsp.remainder;
                    end
                    state_next = ST_FILL;
                end
            end

            ST_FILL:
            begin
                // Each filled hour takes one step of the running quotient,
                // which is already rounded, and is then appended.
                wr_en      = 1'b1;
                wr_addr    = wp_reg;
                wr_data    = '{hour: fill_hour_reg, level: q_l_step[6:0],
                               mv: q_v_step[15:0], marks: {base_sleep_reg, 1'b1}};
                wp_next    = wp_inc;
                total_next = total_inc;
                r_l_next   = carry_l ? 13'(sum_l - {1'b0, span2_reg}) : sum_l[12:0];
                r_v_next   = carry_v ? 13'(sum_v - {1'b0, span2_reg}) : sum_v[12:0];
                q_l_next   = q_l_step;
                q_v_next   = q_v_step;
                fill_hour_next = fill_hour_reg + 32'd1;
                cnt_next   = cnt_reg - 12'd1;
                if (cnt_reg == 12'd1)
                begin
                    state_next = ST_APPEND;
                end
            end

            ST_APPEND:
            begin
                wr_en      = 1'b1;
                wr_addr    = wp_reg;
                wp_next    = wp_inc;
                total_next = total_inc;
                state_next = ST_DONE;
            end

            ST_SCAN_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = ptr_reg;
                state_next = ST_SCAN_CMP;
            end

            ST_SCAN_CMP:
            begin
                if (rd_data.hour == hour_reg)
                begin
                    res_found_next = 1'b1;
                    res_next       = rd_data;
                    state_next     = ST_DONE;
                end
                else if (scan_reg == TW'(1))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    scan_next  = scan_reg - 1'b1;
                    ptr_next   = (ptr_reg == LAST_IDX) ? '0 : ptr_reg + 1'b1;
                    state_next = ST_SCAN_RD;
                end
            end

            ST_DONE:
            begin
                if (!out_valid_reg || result_out.ready)
                begin
                    o_load         = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wp_reg        <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
            max_gap_reg   <= MAX_GAP_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid)
            begin
                max_gap_reg <= cfg.data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg       <= mode_next;
        hour_reg       <= hour_next;
        level_reg      <= level_next;
        mv_reg         <= mv_next;
        sleep_reg      <= sleep_next;
        fill_reg       <= fill_next;
        base_level_reg <= base_level_next;
        base_mv_reg    <= base_mv_next;
        base_sleep_reg <= base_sleep_next;
        span2_reg      <= span2_next;
        cnt_reg        <= cnt_next;
        fill_hour_reg  <= fill_hour_next;
        neg_l_reg      <= neg_l_next;
        neg_v_reg      <= neg_v_next;
        q_l_reg        <= q_l_next;
        q_v_reg        <= q_v_next;
        dq_l_reg       <= dq_l_next;
        dq_v_reg       <= dq_v_next;
        r_l_reg        <= r_l_next;
        r_v_reg        <= r_v_next;
        dr_l_reg       <= dr_l_next;
        dr_v_reg       <= dr_v_next;
        ptr_reg        <= ptr_next;
        scan_reg       <= scan_next;
        res_reg        <= res_next;
        res_found_reg  <= res_found_next;
        if (o_load)
        begin
            // A record never reports an entry; its fields were cleared at accept.
            o_found_reg <= res_found_reg && (mode_reg == MODE_LOOKUP);
            o_level_reg <= res_reg.level;
            o_mv_reg    <= res_reg.mv;
            o_marks_reg <= res_reg.marks;
            o_count_reg <= OUT_COUNT_W'(total_reg);
        end
    end

    assign sample_in.ready = (state_reg == ST_IDLE);
    assign cfg.ready       = 1'b1;

    assign result_out.valid            = out_valid_reg;
    assign result_out.found            = o_found_reg;
    assign result_out.found_level      = o_level_reg;
    assign result_out.found_millivolts = o_mv_reg;
    assign result_out.was_interpolated = o_marks_reg[MARK_INTERP_BIT];
    assign result_out.light_sleep      = o_marks_reg[MARK_LIGHT_BIT];
    assign result_out.deep_sleep       = o_marks_reg[MARK_DEEP_BIT];
    assign result_out.stored_entries   = o_count_reg;

`ifndef SYNTHESIS
    // The entry count can never pass the depth of the log.
    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= DEPTH_T)
        else $error("entry count exceeds log depth");

    // The write position always addresses a real entry.
    a_wp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        wp_reg <= LAST_IDX)
        else $error("write position out of range");

    // Only one item is in flight: after an accept the input closes.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        sample_in.valid && sample_in.ready |=> !sample_in.ready)
        else $error("second item accepted while busy");

    // The memory is never written while waiting for a new item.
    a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !wr_en)
        else $error("entry write while idle");

    // A result is loaded only into a free or draining output register.
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        o_load |-> (!out_valid_reg || result_out.ready))
        else $error("result overwrote a waiting item");
`endif

endmodule
